// File: src/ibm_pkg.sv
`timescale 1ns / 1ps
package ibm_pkg;

  localparam int TickW  = 16;
  localparam int PhaseW = 5;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  localparam logic [TickW-1:0] PhaseTicksReset = 16'd10;

  // Line action for the phase that opens.
  typedef struct packed {
    logic set_scl;
    logic scl_val;
    logic set_sda;
    logic sda_val;
    logic shift_in;
    logic sample_ack;
  } line_act_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       rejected;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_total(input logic [2:0] op);
    logic [PhaseW-1:0] n;
    begin
      case (op)
        OP_START: n = 5'd4;
        OP_STOP:  n = 5'd3;
        OP_WRITE: n = 5'd24;
        OP_READ:  n = 5'd25;
        OP_SACK:  n = 5'd3;
        OP_RACK:  n = 5'd4;
        default:  n = 5'd0;
      endcase
      return n;
    end
  endfunction

  // x / 3 for x < 32 via reciprocal 11/32.
  function automatic logic [3:0] div3(input logic [PhaseW-1:0] x);
    logic [8:0] p;
    begin
      p = {4'd0, x} * 9'd11;
      return p[8:5];
    end
  endfunction

  function automatic logic [1:0] mod3(input logic [PhaseW-1:0] x);
    logic [5:0] t;
    begin
      t = {1'b0, x} - ({2'd0, div3(x)} * 6'd3);
      return t[1:0];
    end
  endfunction

endpackage

// File: src/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// Bit-level I2C master sequencer. Each input transfer is either a timing tick
// or a command (start, stop, write byte, read byte, send ack, read ack); each
// one yields exactly one result transfer with the SCL/SDA drive levels (1 =
// released), busy, a done pulse, the last read byte, the last sampled ack and
// a rejected flag for commands that arrive while busy. Every line phase lasts
// cfg phase_ticks ticks (0 acts as 1, reset value 10). The block is an input
// register, one pass of next-state logic and an output register: it accepts
// one transfer per clock, and the result moves from the input register to the
// output register when the output side is ready; an output stall holds the
// input register and drops in_ready. cfg writes must only happen while idle.
module i2c_bit_level_master (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ibm_pkg::TickW-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_operation,
  input  logic [7:0]              in_tx_byte,
  input  logic                    in_ack_to_send,
  input  logic                    in_sda_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_scl_level,
  output logic                    out_sda_drive,
  output logic                    out_busy_res,
  output logic                    out_done_res,
  output logic [7:0]              out_rx_byte,
  output logic                    out_ack_received,
  output logic                    out_rejected
);
  import ibm_pkg::*;

  logic       in_valid_r;
  logic [2:0] op_r;
  logic [7:0] tx_r;
  logic       ack_send_r;
  logic       sda_r;
  logic       out_valid_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  ibm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .en          (advance),
    .operation   (op_r),
    .tx_byte     (tx_r),
    .ack_to_send (ack_send_r),
    .sda_in      (sda_r),
    .res_nxt     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_operation;
      tx_r       <= in_tx_byte;
      ack_send_r <= in_ack_to_send;
      sda_r      <= in_sda_in;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = res_r.scl_level;
  assign out_sda_drive    = res_r.sda_drive;
  assign out_busy_res     = res_r.busy_res;
  assign out_done_res     = res_r.done_res;
  assign out_rx_byte      = res_r.rx_byte;
  assign out_ack_received = res_r.ack_received;
  assign out_rejected     = res_r.rejected;

endmodule

// File: src/ibm_phase_dec.sv
`timescale 1ns / 1ps
module ibm_phase_dec (
  input  logic [2:0]               cmd,
  input  logic [ibm_pkg::PhaseW-1:0] phase,
  input  logic [7:0]               shift_byte,
  output ibm_pkg::line_act_t       act
);
  import ibm_pkg::*;

  logic [PhaseW-1:0] rd_q;
  logic [1:0]        wr_r;
  logic [1:0]        rd_r;
  logic [2:0]        wr_k;
  logic [3:0]        wr_div;

  always_comb begin
    rd_q   = phase - 5'd1;
    wr_r   = mod3(phase);
    wr_div = div3(phase);
    wr_k   = wr_div[2:0];
    rd_r   = mod3(rd_q);
    act    = '0;
    unique case (cmd)
      OP_START: begin
        case (phase)
          5'd0:    begin act.set_sda = 1'b1; act.sda_val = 1'b1; end
          5'd1:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
          5'd2:    begin act.set_sda = 1'b1; act.sda_val = 1'b0; end
          default: begin act.set_scl = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      OP_STOP: begin
        case (phase)
          5'd0:    begin act.set_sda = 1'b1; act.sda_val = 1'b0; end
          5'd1:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
          default: begin act.set_sda = 1'b1; act.sda_val = 1'b1; end
        endcase
      end
      OP_WRITE: begin
        case (wr_r)
          2'd0:    begin act.set_sda = 1'b1; act.sda_val = shift_byte[3'd7 - wr_k]; end
          2'd1:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
          default: begin act.set_scl = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      OP_READ: begin
        if (phase == 5'd0) begin
          act.set_sda = 1'b1;
          act.sda_val = 1'b1;
        end else begin
          case (rd_r)
            2'd0:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
            2'd1:    act.shift_in = 1'b1;
            default: begin act.set_scl = 1'b1; act.scl_val = 1'b0; end
          endcase
        end
      end
      OP_SACK: begin
        case (phase)
          5'd0:    begin act.set_sda = 1'b1; act.sda_val = shift_byte[0]; end
          5'd1:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
          default: begin act.set_scl = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      OP_RACK: begin
        case (phase)
          5'd0:    begin act.set_sda = 1'b1; act.sda_val = 1'b1; end
          5'd1:    begin act.set_scl = 1'b1; act.scl_val = 1'b1; end
          5'd2:    act.sample_ack = 1'b1;
          default: begin act.set_scl = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      default: act = '0;
    endcase
  end

endmodule

// File: src/ibm_seq.sv
`timescale 1ns / 1ps
module ibm_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ibm_pkg::TickW-1:0] cfg_wr_data,
  input  logic                    en,
  input  logic [2:0]              operation,
  input  logic [7:0]              tx_byte,
  input  logic                    ack_to_send,
  input  logic                    sda_in,
  output ibm_pkg::result_t        res_nxt
);
  import ibm_pkg::*;

  logic [TickW-1:0]  phase_ticks_r;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [TickW-1:0]  tick_r, tick_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              ack_r, ack_nxt;

  logic              busy;
  logic              is_cmd;
  logic              phase_end;
  logic [TickW-1:0]  eff_ticks;
  logic [TickW:0]    tick_inc;
  logic [PhaseW-1:0] phase_inc;
  logic              open_en;
  logic [2:0]        dec_cmd;
  logic [PhaseW-1:0] dec_phase;
  logic [7:0]        dec_shift;
  logic              done, rej;
  line_act_t         act;

  ibm_phase_dec u_dec (
    .cmd        (dec_cmd),
    .phase      (dec_phase),
    .shift_byte (dec_shift),
    .act        (act)
  );

  always_comb begin
    busy      = (cmd_r != OP_TICK);
    is_cmd    = (operation != OP_TICK) && (operation != 3'd7);
    eff_ticks = (phase_ticks_r == '0) ? {{(TickW-1){1'b0}}, 1'b1} : phase_ticks_r;
    tick_inc  = {1'b0, tick_r} + {{TickW{1'b0}}, 1'b1};
    phase_end = tick_inc >= {1'b0, eff_ticks};
    phase_inc = phase_r + 5'd1;

    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    rej       = 1'b0;
    open_en   = 1'b0;
    dec_cmd   = cmd_r;
    dec_phase = phase_inc;
    dec_shift = shift_r;

    if (operation == OP_TICK) begin
      if (busy) begin
        if (phase_end) begin
          tick_nxt = '0;
          if (phase_inc >= phase_total(cmd_r)) begin
            if (cmd_r == OP_READ) rx_nxt = shift_r;
            cmd_nxt   = OP_TICK;
            phase_nxt = '0;
            done      = 1'b1;
          end else begin
            phase_nxt = phase_inc;
            open_en   = 1'b1;
          end
        end else begin
          tick_nxt = tick_inc[TickW-1:0];
        end
      end
    end else if (is_cmd) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        cmd_nxt   = operation;
        phase_nxt = '0;
        tick_nxt  = '0;
        case (operation)
          OP_WRITE: shift_nxt = tx_byte;
          OP_READ:  shift_nxt = 8'd0;
          OP_SACK:  shift_nxt = {7'd0, ack_to_send};
          default:  shift_nxt = shift_r;
        endcase
        dec_cmd   = operation;
        dec_phase = '0;
        dec_shift = shift_nxt;
        open_en   = 1'b1;
      end
    end

    if (open_en) begin
      if (act.set_scl) scl_nxt = act.scl_val;
      if (act.set_sda) sda_nxt = act.sda_val;
      if (act.shift_in) shift_nxt = {shift_r[6:0], sda_in};
      if (act.sample_ack) ack_nxt = sda_in;
    end

    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_drive    = sda_nxt;
    res_nxt.busy_res     = (cmd_nxt != OP_TICK);
    res_nxt.done_res     = done;
    res_nxt.rx_byte      = rx_nxt;
    res_nxt.ack_received = ack_nxt;
    res_nxt.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PhaseTicksReset;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      cmd_r         <= OP_TICK;
      phase_r       <= '0;
      tick_r        <= '0;
      shift_r       <= '0;
      rx_r          <= '0;
      ack_r         <= 1'b1;
    end else begin
      if (cfg_wr_en) phase_ticks_r <= cfg_wr_data;
      if (en) begin
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        shift_r <= shift_nxt;
        rx_r    <= rx_nxt;
        ack_r   <= ack_nxt;
      end
    end
  end

endmodule

// File: sim/i2c_line_checker.sv
`timescale 1ns / 1ps
module i2c_line_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [ibm_pkg::TickW-1:0] cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [2:0]                in_operation,
  input  logic [7:0]                in_tx_byte,
  input  logic                      in_ack_to_send,
  input  logic                      in_sda_in,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_scl_level,
  input  logic                      out_sda_drive,
  input  logic                      out_busy_res,
  input  logic                      out_done_res,
  input  logic [7:0]                out_rx_byte,
  input  logic                      out_ack_received,
  input  logic                      out_rejected,
  output int                        fail_count,
  output int                        pending,
  output logic                      cmd_active
);
  import ibm_pkg::*;

  localparam logic [2:0] CmdIdle = OP_TICK;

  logic [TickW-1:0]  phase_ticks;
  logic              scl_q;
  logic              sda_q;
  logic              ack_q;
  logic [2:0]        cur_cmd;
  logic [PhaseW-1:0] phase;
  logic [TickW-1:0]  tick_cnt;
  logic [7:0]        shreg;
  logic [7:0]        rx_q;
  result_t           line_results[$];

  function automatic logic [PhaseW-1:0] phases_of(input logic [2:0] op);
    case (op)
      OP_START, OP_RACK: return 5'd4;
      OP_STOP, OP_SACK:  return 5'd3;
      OP_WRITE:          return 5'd24;
      OP_READ:           return 5'd25;
      default:           return 5'd0;
    endcase
  endfunction

  // Line action (or SDA sample) for the phase that just opened.
  task automatic open_phase(input logic [PhaseW-1:0] ph, input logic sda_in);
    int unsigned bit_n;
    int unsigned sub;
    case (cur_cmd)
      OP_START: begin
        case (ph)
          0: sda_q = 1'b1;
          1: scl_q = 1'b1;
          2: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (ph)
          0: sda_q = 1'b0;
          1: scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      OP_WRITE: begin
        bit_n = ph / 3;
        sub = ph % 3;
        if (sub == 0) sda_q = shreg[7 - bit_n];
        else scl_q = (sub == 1);
      end
      OP_READ: begin
        if (ph == 0) begin
          sda_q = 1'b1;
        end else begin
          sub = (ph - 1) % 3;
          case (sub)
            0: scl_q = 1'b1;
            1: shreg = {shreg[6:0], sda_in};
            default: scl_q = 1'b0;
          endcase
        end
      end
      OP_SACK: begin
        case (ph)
          0: sda_q = shreg[0];
          1: scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      OP_RACK: begin
        case (ph)
          0: sda_q = 1'b1;
          1: scl_q = 1'b1;
          2: ack_q = sda_in;
          default: scl_q = 1'b0;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic step_line(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic sda, output result_t res);
    logic           done;
    logic           rej;
    logic [TickW:0] eff;
    done = 1'b0;
    rej = 1'b0;
    if (op == OP_TICK) begin
      if (cur_cmd != CmdIdle) begin
        eff = {1'b0, phase_ticks};
        if (eff == '0) eff = {{TickW{1'b0}}, 1'b1};
        if ({1'b0, tick_cnt} + 1 >= eff) begin
          tick_cnt = '0;
          phase = phase + 1'b1;
          if (phase >= phases_of(cur_cmd)) begin
            if (cur_cmd == OP_READ) rx_q = shreg;
            cur_cmd = CmdIdle;
            phase = '0;
            done = 1'b1;
          end else begin
            open_phase(phase, sda);
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
    end else if (op <= OP_RACK) begin
      if (cur_cmd != CmdIdle) begin
        rej = 1'b1;
      end else begin
        cur_cmd = op;
        phase = '0;
        tick_cnt = '0;
        if (op == OP_WRITE) shreg = tx;
        else if (op == OP_READ) shreg = '0;
        else if (op == OP_SACK) shreg = {7'd0, ack};
        open_phase('0, sda);
      end
    end
    res.scl_level = scl_q;
    res.sda_drive = sda_q;
    res.busy_res = (cur_cmd != CmdIdle);
    res.done_res = done;
    res.rx_byte = rx_q;
    res.ack_received = ack_q;
    res.rejected = rej;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : line_monitor
    result_t want;
    if (!rst_n) begin
      phase_ticks = PhaseTicksReset;
      scl_q = 1'b1;
      sda_q = 1'b1;
      ack_q = 1'b1;
      cur_cmd = CmdIdle;
      phase = '0;
      tick_cnt = '0;
      shreg = '0;
      rx_q = '0;
      line_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) phase_ticks = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (line_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected, actual %p", $time,
                   {out_scl_level, out_sda_drive, out_busy_res, out_done_res,
                    out_rx_byte, out_ack_received, out_rejected});
        end else begin
          want = line_results.pop_front();
          check_field("scl_level", want.scl_level, out_scl_level);
          check_field("sda_drive", want.sda_drive, out_sda_drive);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("done_res", want.done_res, out_done_res);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("ack_received", want.ack_received, out_ack_received);
          check_field("rejected", want.rejected, out_rejected);
        end
      end
      if (in_valid && in_ready) begin
        step_line(in_operation, in_tx_byte, in_ack_to_send, in_sda_in, want);
        line_results.push_back(want);
      end
    end
    pending = line_results.size();
    cmd_active = (cur_cmd != CmdIdle);
  end

endmodule

// File: sim/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
module i2c_bit_level_master_tb;
  import ibm_pkg::*;

  localparam logic [2:0] OpNone    = 3'd7;  // neither tick nor command
  localparam int         IdleLimit = 1000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [TickW-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [2:0]       in_operation = OP_TICK;
  logic [7:0]       in_tx_byte = '0;
  logic             in_ack_to_send = 1'b0;
  logic             in_sda_in = 1'b1;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_scl_level;
  logic             out_sda_drive;
  logic             out_busy_res;
  logic             out_done_res;
  logic [7:0]       out_rx_byte;
  logic             out_ack_received;
  logic             out_rejected;

  int   fail_count;
  int   pending;
  logic cmd_active;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  int   free_left = 0;

  always #2 clk = ~clk;

  i2c_bit_level_master u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tx_byte      (in_tx_byte),
    .in_ack_to_send  (in_ack_to_send),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scl_level   (out_scl_level),
    .out_sda_drive   (out_sda_drive),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_received(out_ack_received),
    .out_rejected    (out_rejected)
  );

  i2c_line_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tx_byte      (in_tx_byte),
    .in_ack_to_send  (in_ack_to_send),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scl_level   (out_scl_level),
    .out_sda_drive   (out_sda_drive),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_received(out_ack_received),
    .out_rejected    (out_rejected),
    .fail_count      (fail_count),
    .pending         (pending),
    .cmd_active      (cmd_active)
  );

  // Receiver: free-running stretches, otherwise occasional stalls that hold out_ready low.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (free_left > 0) begin
        free_left <= free_left - 1;
      end else begin
        case ($urandom_range(0, 15))
          0: free_left <= $urandom_range(50, 200);
          1, 2, 3: stall_left <= $urandom_range(1, 12);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transfer; called and returns just after a falling edge.
  task automatic push(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                      input logic sda);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(80, 250);
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_tx_byte <= tx;
    in_ack_to_send <= ack;
    in_sda_in <= sda;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic tick(input logic sda);
    push(OP_TICK, pick_byte(), 1'($urandom), sda);
  endtask

  // Mostly complete commands ticked through to done, with some noise mixed in.
  task automatic run_traffic(input int n);
    int         sent;
    logic [2:0] op;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 31))
        0: push(OpNone, pick_byte(), 1'($urandom), 1'($urandom));
        1: tick(1'($urandom));
        default: begin
          case ($urandom_range(0, 9))
            0: op = OP_START;
            1: op = OP_STOP;
            2, 3: op = OP_WRITE;
            4, 5: op = OP_READ;
            6, 7: op = OP_SACK;
            default: op = OP_RACK;
          endcase
          push(op, pick_byte(), 1'($urandom), 1'($urandom));
          sent++;
          while (cmd_active) begin
            if ($urandom_range(0, 39) == 0)
              push(3'($urandom_range(OP_START, OP_RACK)), pick_byte(), 1'($urandom),
                   1'($urandom));
            else
              tick(1'($urandom));
            sent++;
          end
        end
      endcase
    end
  endtask

  // Finish any running command and let all results drain before the write.
  task automatic set_phase_ticks(input logic [TickW-1:0] v);
    while (cmd_active) tick(1'($urandom));
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_traffic(100);

    // directed: zero phase length acts as one tick per phase
    set_phase_ticks(16'd0);
    tick(1'b0);
    push(OpNone, 8'hFF, 1'b1, 1'b1);
    push(OP_START, 8'h5A, 1'b0, 1'b1);
    push(OP_WRITE, 8'hA5, 1'b1, 1'b0);
    repeat (4) tick(1'b1);
    push(OP_RACK, 8'h00, 1'b0, 1'b1);
    repeat (4) tick(1'b0);
    push(OP_SACK, 8'h00, 1'b1, 1'b0);
    repeat (3) tick(1'b1);
    push(OP_SACK, 8'hFF, 1'b0, 1'b1);
    repeat (3) tick(1'b0);
    push(OP_STOP, 8'h00, 1'b1, 1'b0);
    repeat (3) tick(1'b1);

    run_traffic(200);
    set_phase_ticks(16'd1);
    run_traffic(200);
    set_phase_ticks(16'd2);
    run_traffic(200);
    set_phase_ticks(16'($urandom_range(3, 5)));
    run_traffic(200);

    // widest phase: a start held in its first phase, with a rejected stop
    set_phase_ticks(16'hFFFF);
    push(OP_START, pick_byte(), 1'($urandom), 1'($urandom));
    repeat (40) tick(1'($urandom));
    push(OP_STOP, pick_byte(), 1'($urandom), 1'($urandom));
    push(OpNone, pick_byte(), 1'($urandom), 1'($urandom));
    repeat (40) tick(1'($urandom));

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
